>>> rtl/bbiq_pkg.sv
// shared types and constants for the bounded bitset insert/query block
package bbiq_pkg;

   localparam int DEF_CAPACITY  = 4096;
   localparam int DEF_WORD_BITS = 64;

   localparam int FIELD_W     = 32;
   localparam int TOTAL_W     = 13;
   localparam int CSR_INDEX_W = 2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_LOWER_BOUND = 2'd0;
   localparam csr_index_type CSR_UPPER_BOUND = 2'd1;

   localparam logic signed [FIELD_W-1:0] LOWER_BOUND_RESET = 32'sd0;
   localparam logic signed [FIELD_W-1:0] UPPER_BOUND_RESET = 32'sd4095;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic divide;
      logic lookup;
      logic update;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] lower;
      logic signed [FIELD_W-1:0] upper;
   } bounds_type;

endpackage

>>> rtl/bbiq_csr.sv
// window bound registers and their write port
module bbiq_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  bbiq_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_data,
   output bbiq_pkg::bounds_type    bounds
);
   import bbiq_pkg::*;

   logic signed [FIELD_W-1:0] lower_ff, lower_in;
   logic signed [FIELD_W-1:0] upper_ff, upper_in;

   assign csr_ready = 1'b1;

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOWER_BOUND: lower_in = csr_data;
            CSR_UPPER_BOUND: upper_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= LOWER_BOUND_RESET;
         upper_ff <= UPPER_BOUND_RESET;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   assign bounds.lower = lower_ff;
   assign bounds.upper = upper_ff;

endmodule

>>> rtl/bbiq_ctrl.sv
// sequencer: clearing pass after reset, then one item through four steps
module bbiq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bbiq_pkg::status_type status,
   output bbiq_pkg::cmd_type    cmd
);
   import bbiq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> rtl/bbiq_dpath.sv
// range check, word/bit split, bitmap memory, member count and result registers
module bbiq_dpath #(
   parameter int CAPACITY  = bbiq_pkg::DEF_CAPACITY,
   parameter int WORD_BITS = bbiq_pkg::DEF_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bbiq_pkg::cmd_type    cmd,
   output bbiq_pkg::status_type status,
   input  bbiq_pkg::bounds_type bounds,
   input  logic                 req_kind,
   input  logic signed [31:0]   req_value,
   output logic                 rsp_strobe,
   output logic                 rsp_present,
   output logic                 rsp_added,
   output logic                 rsp_out_of_range,
   output logic [12:0]          rsp_member_total
);
   import bbiq_pkg::*;

   localparam int OFF_W     = $clog2(CAPACITY);
   localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int REM_W     = OFF_W + 1;
   // reciprocal estimate is at most one low, fixed by one compare
   localparam int DIV_SHIFT = OFF_W + 7;
   localparam int PROD_W    = OFF_W + DIV_SHIFT;
   localparam logic [PROD_W-1:0] RECIP = PROD_W'((2 ** DIV_SHIFT) / WORD_BITS);
   localparam logic [FIELD_W:0]  CAP_LAST = (FIELD_W + 1)'(CAPACITY - 1);

   logic                 kind_ff;
   logic                 oor_ff, oor_in;
   logic [OFF_W-1:0]     off_ff;
   logic [OFF_W-1:0]     quot_ff, quot_in;
   logic [ADDR_W-1:0]    word_ff, word_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [WORD_BITS-1:0] rdata_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_strobe_ff;
   logic                 rsp_present_ff, rsp_added_ff, rsp_oor_ff;
   logic [TOTAL_W-1:0]   rsp_total_ff;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];

   logic [FIELD_W:0]     diff;
   logic [PROD_W-1:0]    prod;
   logic [REM_W-1:0]     quot_times_w, rem, rem_fix;
   logic                 fix;
   logic [OFF_W-1:0]     word_q;
   logic                 present, do_set;

   // window check on the incoming value
   always_comb begin
      diff   = {req_value[FIELD_W-1], req_value} - {bounds.lower[FIELD_W-1], bounds.lower};
      oor_in = diff[FIELD_W] || (req_value > bounds.upper) || (diff > CAP_LAST);
   end

   // offset / WORD_BITS by reciprocal multiply
   always_comb begin
      prod    = PROD_W'(off_ff) * RECIP;
      quot_in = prod[DIV_SHIFT +: OFF_W];
   end

   // remainder and one-step correction
   always_comb begin
      quot_times_w = REM_W'(quot_ff) * REM_W'(WORD_BITS);
      rem          = {1'b0, off_ff} - quot_times_w;
      rem_fix      = rem - REM_W'(WORD_BITS);
      fix          = (rem >= REM_W'(WORD_BITS));
      word_q       = fix ? (quot_ff + OFF_W'(1)) : quot_ff;
      word_in      = word_q[ADDR_W-1:0];
      bit_in       = fix ? rem_fix[BIT_W-1:0] : rem[BIT_W-1:0];
   end

   always_comb begin
      present  = !oor_ff && rdata_ff[bit_ff];
      do_set   = cmd.update && kind_ff && !present && !oor_ff;
      count_in = do_set ? (count_ff + CNT_W'(1)) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         oor_ff  <= oor_in;
         off_ff  <= diff[OFF_W-1:0];
      end
      if (cmd.divide) begin
         quot_ff <= quot_in;
      end
      if (cmd.lookup) begin
         word_ff <= word_in;
         bit_ff  <= bit_in;
      end
   end

   // bitmap store
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_ff] <= '0;
      end else if (do_set) begin
         mem[word_ff] <= rdata_ff | (WORD_BITS'(1) << bit_ff);
      end
      if (cmd.lookup) begin
         rdata_ff <= mem[word_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_present_ff <= present;
         rsp_added_ff   <= do_set;
         rsp_oor_ff     <= oor_ff;
         rsp_total_ff   <= TOTAL_W'(count_in);
      end
   end

   assign status.clear_last = (clr_ff == ADDR_W'(NUM_WORDS - 1));

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_present      = rsp_present_ff;
   assign rsp_added        = rsp_added_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_member_total = rsp_total_ff;

endmodule

>>> rtl/bounded_bitset_insert_query.sv
// top level of the bounded bitset insert/query block
//
//   channel   handshake              payload
//   request   start / busy           req_kind, req_value
//   response  rsp_strobe (1 cycle)   rsp_present, rsp_added, rsp_out_of_range,
//                                    rsp_member_total
//   csr       csr_valid / csr_ready  csr_index, csr_data
//
// an item goes from acceptance to its response strobe through capture and
// window check, reciprocal divide to word index, registered memory read,
// then read-modify-write of one bitmap word with the count update
// busy drops in the cycle the strobe shows, so the next item can go in as its response shows
// after reset a clearing pass zeroes every bitmap word, one word a cycle,
// with busy held high; csr writes are taken throughout
// the response side cannot stall: each result shows for exactly one cycle
module bounded_bitset_insert_query #(
   parameter int CAPACITY  = bbiq_pkg::DEF_CAPACITY,
   parameter int WORD_BITS = bbiq_pkg::DEF_WORD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   // request items
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_kind,
   input  logic signed [31:0]      req_value,
   // response items
   output logic                    rsp_strobe,
   output logic                    rsp_present,
   output logic                    rsp_added,
   output logic                    rsp_out_of_range,
   output logic [12:0]             rsp_member_total,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  bbiq_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_data
);
   import bbiq_pkg::*;

   cmd_type    cmd;
   status_type status;
   bounds_type bounds;

   // lower and upper bound of the window
   bbiq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bounds    (bounds)
   );

   // sequencing of the clearing pass and of each item
   bbiq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // bitmap, member count and result registers
   bbiq_dpath #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .bounds           (bounds),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_present      (rsp_present),
      .rsp_added        (rsp_added),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_member_total (rsp_member_total)
   );

endmodule
